[design/vna_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vna_pkg: shared types and constants of the vertex normal accumulator
// Holds the field widths, the arithmetic widths of the normalizing datapath,
// the sequencer step limits and the command and status types.
// ----------------------------------------------------------------------------
package vna_pkg;

  // Default sizes of the vertex tables.
  localparam int unsigned MAX_VERTICES_DEF = 4096;
  localparam int unsigned SUM_WIDTH_DEF    = 32;

  // Field widths.
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned POS_W  = 24;
  localparam int unsigned NRM_W  = 16;
  localparam int unsigned EDGE_W = POS_W + 1;

  // Normalizer widths: vectors, magnitudes, partial products, squares, root.
  localparam int unsigned VEC_W  = 53;
  localparam int unsigned MAG_W  = VEC_W - 1;
  localparam int unsigned HALF_W = MAG_W / 2;
  localparam int unsigned MUL_W  = HALF_W + 1;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned SQ_W   = 2 * MAG_W + 2;
  localparam int unsigned ROOT_W = SQ_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 3;
  localparam int unsigned DREM_W = ROOT_W + 1;

  // Sequencer step counter and the last step of each phase.
  localparam int unsigned STEP_W = 6;
  localparam logic [STEP_W-1:0] FETCH_LAST = 6'd3;
  localparam logic [STEP_W-1:0] CROSS_LAST = 6'd6;
  localparam logic [STEP_W-1:0] SQR_LAST   = 6'd9;
  localparam logic [STEP_W-1:0] SQRT_LAST  = STEP_W'(ROOT_W);
  localparam logic [STEP_W-1:0] DIV_LAST   = 6'd47;
  localparam logic [STEP_W-1:0] UPD_LAST   = 6'd5;

  // Largest Q1.15 magnitude, also the y of the default up normal.
  localparam logic signed [NRM_W-1:0] NRM_MAX = 16'sd32767;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TRI   = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Datapath phase selected by the controller.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_CLEAR = 4'd1,
    PH_WRV   = 4'd2,
    PH_FETCH = 4'd3,
    PH_CROSS = 4'd4,
    PH_SQR   = 4'd5,
    PH_SQRT  = 4'd6,
    PH_DIV   = 4'd7,
    PH_UPD   = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [STEP_W-1:0] step;
    logic              load_in;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic chk_ok;
    logic s_zero;
  } stat_t;

  // Squared-length terms: component and partial product of term t.
  function automatic logic [1:0] sq_comp(input logic [3:0] t);
    logic [1:0] c;
    case (t)
      4'd0, 4'd1, 4'd2: c = 2'd0;
      4'd3, 4'd4, 4'd5: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] sq_part(input logic [3:0] t);
    logic [1:0] p;
    case (t)
      4'd0, 4'd3, 4'd6: p = 2'd0;
      4'd1, 4'd4, 4'd7: p = 2'd1;
      default:          p = 2'd2;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

[design/vna_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vna_ram: single-port RAM with registered read
// One write and one read per cycle at one shared address; read data is registered and appears in the next cycle.
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port share the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[design/vna_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vna_ctrl: sequencer of the vertex normal accumulator
// Walks a triangle through fetch, cross product, squared length, square root,
// division and sum update; reads skip cross and update. Owns both handshakes.
// ----------------------------------------------------------------------------
module vna_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     opcode,
  output logic           out_valid,
  input  logic           out_ready,
  output vna_pkg::cmd_t  cmd,
  input  vna_pkg::stat_t stat
);
  import vna_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_WRV   = 11'b00000000100,
    S_FETCH = 11'b00000001000,
    S_CHECK = 11'b00000010000,
    S_CROSS = 11'b00000100000,
    S_SQR   = 11'b00001000000,
    S_SQRT  = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_UPD   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step;
  op_t               op;
  logic              accept;
  logic              load_out;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (stat.clr_done) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (op_t'(opcode))
            OP_WRITE:        state_next = S_WRV;
            OP_TRI, OP_READ: state_next = S_FETCH;
            default:         state_next = S_DONE;
          endcase
        end
      end
      S_WRV:   state_next = S_DONE;
      S_FETCH: if (step == FETCH_LAST) state_next = S_CHECK;
      S_CHECK: begin
        if (!stat.chk_ok) begin
          state_next = S_DONE;
        end else if (op == OP_TRI) begin
          state_next = S_CROSS;
        end else begin
          state_next = S_SQR;
        end
      end
      S_CROSS: if (step == CROSS_LAST) state_next = S_SQR;
      S_SQR:   if (step == SQR_LAST) state_next = S_SQRT;
      S_SQRT: begin
        if (step == '0 && stat.s_zero) begin
          state_next = S_DONE;
        end else if (step == SQRT_LAST) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (step == DIV_LAST) state_next = (op == OP_TRI) ? S_UPD : S_DONE;
      end
      S_UPD:  if (step == UPD_LAST) state_next = S_DONE;
      S_DONE: if (load_out) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // State, step counter, latched opcode and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      step      <= '0;
      op        <= OP_NOP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= (state_next != state) ? '0 : step + 1'b1;
      if (accept) begin
        op <= op_t'(opcode);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Phase decode for the datapath.
  always_comb begin
    cmd.step     = step;
    cmd.load_in  = accept;
    cmd.load_out = load_out;
    unique case (state)
      S_CLEAR: cmd.phase = PH_CLEAR;
      S_WRV:   cmd.phase = PH_WRV;
      S_FETCH: cmd.phase = PH_FETCH;
      S_CROSS: cmd.phase = PH_CROSS;
      S_SQR:   cmd.phase = PH_SQR;
      S_SQRT:  cmd.phase = PH_SQRT;
      S_DIV:   cmd.phase = PH_DIV;
      S_UPD:   cmd.phase = PH_UPD;
      default: cmd.phase = PH_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[design/vna_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vna_dp: datapath of the vertex normal accumulator
// Vertex tables, one shared multiplier, a bit-serial square root, a
// bit-serial divider, the saturating sum update and the result register.
// ----------------------------------------------------------------------------
module vna_dp #(
  parameter int unsigned MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
  parameter int unsigned SUM_WIDTH    = vna_pkg::SUM_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  vna_pkg::cmd_t                      cmd,
  output vna_pkg::stat_t                     stat,
  input  logic [1:0]                         opcode,
  input  logic [vna_pkg::IDX_W-1:0]          index_a,
  input  logic [vna_pkg::IDX_W-1:0]          index_b,
  input  logic [vna_pkg::IDX_W-1:0]          index_c,
  input  logic signed [vna_pkg::POS_W-1:0]   pos_x,
  input  logic signed [vna_pkg::POS_W-1:0]   pos_y,
  input  logic signed [vna_pkg::POS_W-1:0]   pos_z,
  output logic                               status,
  output logic                               has_normal,
  output logic signed [vna_pkg::NRM_W-1:0]   normal_x,
  output logic signed [vna_pkg::NRM_W-1:0]   normal_y,
  output logic signed [vna_pkg::NRM_W-1:0]   normal_z
);
  import vna_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned SW3 = 3 * SUM_WIDTH;

  // Captured item.
  op_t              op;
  logic [IDX_W-1:0] idx [3];
  logic signed [POS_W-1:0] in_pos [3];

  // Fetched corners, working vector, squared length, root, quotients.
  logic                    wbit [3];
  logic signed [POS_W-1:0] pos [3][3];
  logic signed [VEC_W-1:0] v [3];
  logic [MAG_W-1:0]        mag [3];
  logic signed [PROD_W-1:0] prod;
  logic [SQ_W-1:0]         sq;
  logic [SQ_W-1:0]         rad;
  logic [REM_W-1:0]        rem;
  logic [ROOT_W-1:0]       root;
  logic [DREM_W-1:0]       drem;
  logic [NRM_W-1:0]        dq;
  logic signed [NRM_W-1:0] n [3];
  logic [AW-1:0]           clr_cnt;

  // RAM ports.
  logic [AW-1:0]    addr;
  logic             w_we, w_wdata, w_rd;
  logic             p_we;
  logic [3*POS_W-1:0] p_rd;
  logic             s_we;
  logic [SW3-1:0]   s_wdata, s_rd;

  logic             rng [3];
  logic [1:0]       corner;
  logic [IDX_W-1:0] cur_idx;
  logic [1:0]       cap;
  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [3:0]       t_prev;
  logic [1:0]       sc, sp;
  logic [MAG_W-1:0] sq_mag;
  logic [REM_W-1:0] rem_sh, trial;
  logic [1:0]       dcomp;
  logic [MAG_W-1:0] dm;
  logic [DREM_W-1:0] d_r2, d_len;
  logic             d_ge;
  logic [NRM_W-1:0] q_new, q_sat;
  logic             chk_ok;

  // Values loaded into the result register.
  logic                    status_next;
  logic                    has_normal_next;
  logic signed [NRM_W-1:0] normal_x_next, normal_y_next, normal_z_next;

  function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] s,
                                                   input logic signed [NRM_W-1:0] a);
    logic signed [SUM_WIDTH:0] r;
    logic [SUM_WIDTH-1:0] res;
    r = (SUM_WIDTH+1)'($signed(s)) + (SUM_WIDTH+1)'(a);
    if (r[SUM_WIDTH] != r[SUM_WIDTH-1]) begin
      res = r[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      res = r[SUM_WIDTH-1:0];
    end
    return res;
  endfunction

  // Range checks and corner selection.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rng[k] = 32'(idx[k]) < 32'(MAX_VERTICES);
    end
    corner = (cmd.phase == PH_UPD) ? cmd.step[2:1] : cmd.step[1:0];
    case (corner)
      2'd1:    cur_idx = idx[1];
      2'd2:    cur_idx = idx[2];
      default: cur_idx = idx[0];
    endcase
    if (cmd.phase == PH_CLEAR) begin
      addr = clr_cnt;
    end else begin
      addr = AW'(32'(cur_idx));
    end
  end

  assign chk_ok = (op == OP_TRI) ? (rng[0] && rng[1] && rng[2] && wbit[0] && wbit[1] && wbit[2])
                                 : (rng[0] && wbit[0]);

  // Table write enables and data.
  assign w_we    = (cmd.phase == PH_CLEAR) || (cmd.phase == PH_WRV && rng[0]);
  assign w_wdata = (cmd.phase == PH_WRV);
  assign p_we    = (cmd.phase == PH_WRV) && rng[0];
  assign s_we    = (cmd.phase == PH_WRV && rng[0]) || (cmd.phase == PH_UPD && cmd.step[0]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_wdata[i*SUM_WIDTH +: SUM_WIDTH] = (cmd.phase == PH_WRV) ? '0 :
          sat_add(s_rd[i*SUM_WIDTH +: SUM_WIDTH], n[i]);
    end
  end

  vna_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_written (
    .clk(clk), .we(w_we), .addr(addr), .wdata(w_wdata), .rdata(w_rd)
  );
  vna_ram #(.WIDTH(3 * POS_W), .DEPTH(MAX_VERTICES)) u_pos (
    .clk(clk), .we(p_we), .addr(addr), .wdata({in_pos[2], in_pos[1], in_pos[0]}),
    .rdata(p_rd)
  );
  vna_ram #(.WIDTH(SW3), .DEPTH(MAX_VERTICES)) u_sums (
    .clk(clk), .we(s_we), .addr(addr), .wdata(s_wdata), .rdata(s_rd)
  );

  // Edges and magnitudes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i]  = EDGE_W'(pos[1][i]) - EDGE_W'(pos[0][i]);
      e2[i]  = EDGE_W'(pos[2][i]) - EDGE_W'(pos[0][i]);
      mag[i] = v[i][VEC_W-1] ? MAG_W'(-v[i]) : MAG_W'(v[i]);
    end
  end

  // Multiplier operands for cross product terms and squared length terms.
  always_comb begin
    t_prev = 4'(cmd.step - 1'b1);
    sc     = sq_comp(cmd.step[3:0]);
    sp     = sq_part(cmd.step[3:0]);
    case (sc)
      2'd1:    sq_mag = mag[1];
      2'd2:    sq_mag = mag[2];
      default: sq_mag = mag[0];
    endcase
    mul_a = '0;
    mul_b = '0;
    if (cmd.phase == PH_CROSS) begin
      case (cmd.step)
        6'd0: begin mul_a = MUL_W'(e1[1]); mul_b = MUL_W'(e2[2]); end
        6'd1: begin mul_a = MUL_W'(e1[2]); mul_b = MUL_W'(e2[1]); end
        6'd2: begin mul_a = MUL_W'(e1[2]); mul_b = MUL_W'(e2[0]); end
        6'd3: begin mul_a = MUL_W'(e1[0]); mul_b = MUL_W'(e2[2]); end
        6'd4: begin mul_a = MUL_W'(e1[0]); mul_b = MUL_W'(e2[1]); end
        6'd5: begin mul_a = MUL_W'(e1[1]); mul_b = MUL_W'(e2[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      case (sp)
        2'd0: begin
          mul_a = {1'b0, sq_mag[HALF_W-1:0]};
          mul_b = {1'b0, sq_mag[HALF_W-1:0]};
        end
        2'd1: begin
          mul_a = {1'b0, sq_mag[MAG_W-1:HALF_W]};
          mul_b = {1'b0, sq_mag[HALF_W-1:0]};
        end
        default: begin
          mul_a = {1'b0, sq_mag[MAG_W-1:HALF_W]};
          mul_b = {1'b0, sq_mag[MAG_W-1:HALF_W]};
        end
      endcase
    end
  end

  // One square-root digit per step.
  assign rem_sh = {rem[REM_W-3:0], rad[SQ_W-1:SQ_W-2]};
  assign trial  = REM_W'({root, 2'b01});

  // One quotient bit per step.
  always_comb begin
    dcomp = cmd.step[5:4];
    case (dcomp)
      2'd1:    dm = mag[1];
      2'd2:    dm = mag[2];
      default: dm = mag[0];
    endcase
    d_len = DREM_W'(root);
    d_r2  = (cmd.step[3:0] == 4'd0) ? DREM_W'(dm) : {drem[DREM_W-2:0], 1'b0};
    d_ge  = d_r2 >= d_len;
    q_new = {dq[NRM_W-2:0], d_ge};
    q_sat = (q_new > NRM_W'(NRM_MAX)) ? NRM_W'(NRM_MAX) : q_new;
  end

  assign cap = 2'(cmd.step - 1'b1);

  // Result of the current item: status, and the normal for a good read.
  always_comb begin
    status_next     = 1'b0;
    has_normal_next = 1'b0;
    normal_x_next   = '0;
    normal_y_next   = '0;
    normal_z_next   = '0;
    case (op)
      OP_WRITE: status_next = !rng[0];
      OP_TRI:   status_next = !chk_ok;
      OP_READ: begin
        status_next = !chk_ok;
        if (chk_ok) begin
          has_normal_next = 1'b1;
          if (sq == '0) begin
            normal_y_next = NRM_MAX;
          end else begin
            normal_x_next = n[0];
            normal_y_next = n[1];
            normal_z_next = n[2];
          end
        end
      end
      default: status_next = 1'b0;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op        <= op_t'(opcode);
      idx[0]    <= index_a;
      idx[1]    <= index_b;
      idx[2]    <= index_c;
      in_pos[0] <= pos_x;
      in_pos[1] <= pos_y;
      in_pos[2] <= pos_z;
    end

    // Corner fetch: data of the corner addressed in the previous cycle.
    if (cmd.phase == PH_FETCH && cmd.step != '0) begin
      case (cap)
        2'd0: begin
          wbit[0] <= w_rd;
          for (int i = 0; i < 3; i++) begin
            pos[0][i] <= p_rd[i*POS_W +: POS_W];
            v[i]      <= VEC_W'($signed(s_rd[i*SUM_WIDTH +: SUM_WIDTH]));
          end
        end
        2'd1: begin
          wbit[1] <= w_rd;
          for (int i = 0; i < 3; i++) pos[1][i] <= p_rd[i*POS_W +: POS_W];
        end
        default: begin
          wbit[2] <= w_rd;
          for (int i = 0; i < 3; i++) pos[2][i] <= p_rd[i*POS_W +: POS_W];
        end
      endcase
    end

    // Shared multiplier, registered.
    prod <= mul_a * mul_b;

    // Cross product accumulation, one registered product per step.
    if (cmd.phase == PH_CROSS && cmd.step != '0) begin
      if (!t_prev[0]) begin
        v[t_prev[2:1]] <= VEC_W'(prod);
      end else begin
        v[t_prev[2:1]] <= v[t_prev[2:1]] - VEC_W'(prod);
      end
    end

    // Squared length accumulation.
    if (cmd.phase == PH_SQR) begin
      if (cmd.step == '0) begin
        sq <= '0;
      end else begin
        case (sq_part(t_prev))
          2'd0:    sq <= sq + SQ_W'(unsigned'(prod));
          2'd1:    sq <= sq + (SQ_W'(unsigned'(prod)) << (HALF_W + 1));
          default: sq <= sq + (SQ_W'(unsigned'(prod)) << (2 * HALF_W));
        endcase
      end
    end

    // Square root iterations.
    if (cmd.phase == PH_SQRT) begin
      if (cmd.step == '0) begin
        rad  <= sq;
        rem  <= '0;
        root <= '0;
      end else begin
        rad <= {rad[SQ_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
    end

    // Division iterations, sixteen per component.
    if (cmd.phase == PH_DIV) begin
      drem <= d_ge ? d_r2 - d_len : d_r2;
      dq   <= (cmd.step[3:0] == 4'd0) ? NRM_W'(d_ge) : q_new;
      if (cmd.step[3:0] == 4'hf) begin
        n[dcomp] <= v[dcomp][VEC_W-1] ? -$signed(q_sat) : $signed(q_sat);
      end
    end

    // Result register.
    if (cmd.load_out) begin
      status     <= status_next;
      has_normal <= has_normal_next;
      normal_x   <= normal_x_next;
      normal_y   <= normal_y_next;
      normal_z   <= normal_z_next;
    end
  end

  // Clearing pass over the written flags after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.phase == PH_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign stat.clr_done = (clr_cnt == AW'(MAX_VERTICES - 1));
  assign stat.chk_ok   = chk_ok;
  assign stat.s_zero   = (sq == '0);

endmodule
`default_nettype wire

[design/vertex_normal_accumulator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_top: averaged vertex normal accumulator
// Stores vertex positions, accumulates unit face normals per vertex and
// returns the normalized sum of a vertex on request.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one item per transfer:
//   write vertex, add triangle, read normal, or no-op. Every item produces
//   exactly one result transfer on the output channel (out_valid/out_ready).
//   Items are processed one at a time; in_ready is high only when idle.
//   Writes and no-ops skip the arithmetic. A triangle or read runs the
//   bit-serial square root (53 steps) and the bit-serial divider (16 steps
//   for each of three components), which share one datapath; the item ends
//   early when a vertex is missing or the vector has zero length.
//   After reset the block clears its written flags, one entry a cycle, over
//   all MAX_VERTICES entries, with in_ready low. The result sits in an output
//   register; a new item may be taken while it waits, but that item does
//   not complete until the receiver takes the earlier result.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_top #(
  parameter int unsigned MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
  parameter int unsigned SUM_WIDTH    = vna_pkg::SUM_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         opcode,
  input  logic [vna_pkg::IDX_W-1:0]          index_a,
  input  logic [vna_pkg::IDX_W-1:0]          index_b,
  input  logic [vna_pkg::IDX_W-1:0]          index_c,
  input  logic signed [vna_pkg::POS_W-1:0]   pos_x,
  input  logic signed [vna_pkg::POS_W-1:0]   pos_y,
  input  logic signed [vna_pkg::POS_W-1:0]   pos_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               status,
  output logic                               has_normal,
  output logic signed [vna_pkg::NRM_W-1:0]   normal_x,
  output logic signed [vna_pkg::NRM_W-1:0]   normal_y,
  output logic signed [vna_pkg::NRM_W-1:0]   normal_z
);
  import vna_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  vna_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .stat(stat)
  );

  // Tables and arithmetic.
  vna_dp #(.MAX_VERTICES(MAX_VERTICES), .SUM_WIDTH(SUM_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .opcode(opcode),
    .index_a(index_a), .index_b(index_b), .index_c(index_c),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .status(status), .has_normal(has_normal),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
  );

endmodule
`default_nettype wire

[design/vna_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vna_checker: port-level checks of the vertex normal accumulator
// Watches the result channel and the reset behavior of the top level.
// ----------------------------------------------------------------------------
module vna_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             status,
  input logic                             has_normal,
  input logic signed [vna_pkg::NRM_W-1:0] normal_x,
  input logic signed [vna_pkg::NRM_W-1:0] normal_y,
  input logic signed [vna_pkg::NRM_W-1:0] normal_z
);

  // A stalled result stays valid and keeps its status and normal_y until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(normal_y))
    else $error("stalled result changed");

  // A normal is only reported for a successful read.
  a_has_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_normal |-> !status)
    else $error("normal reported with error status");

  // Normal fields are zero whenever no normal is reported.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_normal |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("normal fields nonzero without a normal");

  // The clearing pass keeps the block closed right after reset.
  a_clear: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block open right after reset");

endmodule

bind vertex_normal_accumulator_top vna_checker u_vna_checker (.*);
`default_nettype wire

[sim/vertex_normal_accumulator_top_test.sv]
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_top_test: self-checking bench of the accumulator
// Drives write, triangle, read and no-op items over the input channel. It
// predicts each result with its own integer model of the position table, the
// per-vertex normal sums and the written flags, and checks every output
// transfer in order. Sender idling and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vna_pkg::*;

  localparam int NUM_RANDOM   = 1230;
  localparam int VERTEX_COUNT = 4096;

  typedef struct {
    op_t                     op;
    logic [IDX_W-1:0]        ia, ib, ic;
    logic signed [POS_W-1:0] px, py, pz;
    bit                      drain;
  } mesh_cmd_t;

  typedef struct {
    logic                    status;
    logic                    has;
    logic signed [NRM_W-1:0] nx, ny, nz;
  } normal_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic [IDX_W-1:0] index_a = '0, index_b = '0, index_c = '0;
  logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic status, has_normal;
  logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;

  mesh_cmd_t      cmd_queue[$];
  normal_result_t expected_normals[$];
  int             error_count = 0;
  int             accepted = 0;
  int             planned_count = 0;
  bit             taken = 1'b0;

  // Predictor state.
  longint vert_pos[VERTEX_COUNT][3];
  longint vert_sum[VERTEX_COUNT][3];
  bit     vert_written[VERTEX_COUNT];

  vertex_normal_accumulator_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .index_a(index_a), .index_b(index_b), .index_c(index_c),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .has_normal(has_normal), .normal_x(normal_x), .normal_y(normal_y),
    .normal_z(normal_z)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("vertex_normal_accumulator_top_test: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    error_count++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, field, got, want);
  endtask

  // Append one item to the stimulus queue.
  task automatic queue_cmd(input mesh_cmd_t m);
    cmd_queue.insert(cmd_queue.size(), m);
  endtask

  // Scale a vector to Q1.15 with a truncating root and truncating divides.
  function automatic bit unit_vector(input longint v[3], output longint n[3]);
    logic [127:0] mag[3];
    logic [127:0] sq, root, cand, q;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? 128'(-v[i]) : 128'(v[i]);
      sq += mag[i] * mag[i];
    end
    if (sq == 0) return 1'b0;
    root = '0;
    for (int b = 52; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= sq) root = cand;
    end
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << 15) / root;
      if (q > 32767) q = 32767;
      n[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint clamp_sum(input longint s);
    if (s > 64'sd2147483647) return 64'sd2147483647;
    if (s < -64'sd2147483648) return -64'sd2147483648;
    return s;
  endfunction

  // Apply one item to the predictor and return the result it causes.
  function automatic normal_result_t accumulate_normal(input mesh_cmd_t c);
    normal_result_t r;
    longint e1[3], e2[3], cr[3], f[3], n[3];
    int a, b, d;
    r = '{1'b0, 1'b0, '0, '0, '0};
    a = int'(c.ia);
    b = int'(c.ib);
    d = int'(c.ic);
    case (c.op)
      OP_WRITE: begin
        vert_pos[a][0] = c.px;
        vert_pos[a][1] = c.py;
        vert_pos[a][2] = c.pz;
        vert_sum[a] = '{0, 0, 0};
        vert_written[a] = 1'b1;
      end
      OP_TRI: begin
        if (!vert_written[a] || !vert_written[b] || !vert_written[d]) begin
          r.status = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            e1[i] = vert_pos[b][i] - vert_pos[a][i];
            e2[i] = vert_pos[d][i] - vert_pos[a][i];
          end
          cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
          cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
          cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
          if (unit_vector(cr, f)) begin
            for (int i = 0; i < 3; i++) begin
              vert_sum[a][i] = clamp_sum(vert_sum[a][i] + f[i]);
              vert_sum[b][i] = clamp_sum(vert_sum[b][i] + f[i]);
              vert_sum[d][i] = clamp_sum(vert_sum[d][i] + f[i]);
            end
          end
        end
      end
      OP_READ: begin
        if (!vert_written[a]) begin
          r.status = 1'b1;
        end else begin
          r.has = 1'b1;
          if (!unit_vector(vert_sum[a], n)) n = '{0, 32767, 0};
          r.nx = NRM_W'(n[0]);
          r.ny = NRM_W'(n[1]);
          r.nz = NRM_W'(n[2]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic mesh_cmd_t make_cmd(input op_t op, input int a, input int b, input int c,
                                         input int x, input int y, input int z);
    mesh_cmd_t m;
    m.op = op;
    m.ia = IDX_W'(a);
    m.ib = IDX_W'(b);
    m.ic = IDX_W'(c);
    m.px = POS_W'(x);
    m.py = POS_W'(y);
    m.pz = POS_W'(z);
    m.drain = 1'b0;
    return m;
  endfunction

  function automatic int rand_vertex();
    if ($urandom_range(0, 99) < 88) return $urandom_range(0, 47);
    return $urandom_range(0, 4095);
  endfunction

  function automatic int rand_coord(input bit wide);
    if (wide) return $signed(24'($urandom));
    return $signed($urandom_range(0, 131071)) - 65536;
  endfunction

  // Checking and prediction at the rising edge.
  always @(posedge clk) begin
    normal_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_normals.size() == 0) begin
        error_count++;
        $display("%0t result transfer with nothing expected", $realtime);
      end else begin
        want = expected_normals.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (has_normal !== want.has) report_mismatch("has_normal", has_normal, want.has);
        if (normal_x !== want.nx) report_mismatch("normal_x", normal_x, want.nx);
        if (normal_y !== want.ny) report_mismatch("normal_y", normal_y, want.ny);
        if (normal_z !== want.nz) report_mismatch("normal_z", normal_z, want.nz);
      end
    end
    if (!rst && in_valid && in_ready) begin
      expected_normals.insert(expected_normals.size(),
        accumulate_normal(make_cmd(op_t'(opcode), int'(index_a), int'(index_b),
          int'(index_c), int'(pos_x), int'(pos_y), int'(pos_z))));
      accepted++;
      taken <= 1'b1;
    end else begin
      taken <= 1'b0;
    end
  end

  // Driver and receiver stalls at the falling edge; idling depends on phase.
  always @(negedge clk) begin
    int phase, send_idle, recv_stall;
    mesh_cmd_t c;
    phase = (planned_count > 0) ? (accepted * 4) / planned_count : 0;
    send_idle = (phase == 1) ? 53 : (phase == 3) ? 33 : 0;
    recv_stall = (phase == 2) ? 53 : (phase == 3) ? 33 : 0;
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
    if (!rst && !(in_valid && !taken)) begin
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle &&
          !(cmd_queue[0].drain && expected_normals.size() != 0)) begin
        c = cmd_queue.pop_front();
        opcode <= c.op;
        index_a <= c.ia;
        index_b <= c.ib;
        index_c <= c.ic;
        pos_x <= c.px;
        pos_y <= c.py;
        pos_z <= c.pz;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    mesh_cmd_t m;
    int r;
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    // Directed: unwritten reads and triangles, extremes, degenerate faces.
    queue_cmd(make_cmd(OP_READ, 5, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(OP_TRI, 0, 1, 2, 0, 0, 0));
    queue_cmd(make_cmd(OP_WRITE, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(OP_WRITE, 1, 0, 0, mx, 0, 0));
    queue_cmd(make_cmd(OP_WRITE, 2, 0, 0, 0, mx, 0));
    queue_cmd(make_cmd(OP_WRITE, 4095, 0, 0, mn, mn, mn));
    queue_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(OP_TRI, 0, 1, 3, 0, 0, 0));
    queue_cmd(make_cmd(OP_TRI, 0, 1, 2, 0, 0, 0));
    queue_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(OP_TRI, 0, 0, 1, 0, 0, 0));
    queue_cmd(make_cmd(OP_TRI, 4095, 1, 2, 0, 0, 0));
    queue_cmd(make_cmd(OP_TRI, 4095, 2, 1, 0, 0, 0));
    queue_cmd(make_cmd(OP_TRI, 1, 1, 2, 0, 0, 0));
    queue_cmd(make_cmd(OP_READ, 4095, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(OP_READ, 1, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(OP_READ, 2, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(OP_NOP, 4095, 4095, 4095, mn, mx, -1));
    queue_cmd(make_cmd(OP_WRITE, 4095, 0, 0, mx, mx, mx));
    queue_cmd(make_cmd(OP_READ, 4095, 0, 0, 0, 0, 0));
    // Random: mostly well-formed meshes on a small vertex pool.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        m = make_cmd(OP_WRITE, rand_vertex(), 0, 0, 0, 0, 0);
        m.px = POS_W'(rand_coord($urandom_range(0, 3) == 0));
        m.py = POS_W'(rand_coord($urandom_range(0, 3) == 0));
        m.pz = POS_W'(rand_coord($urandom_range(0, 3) == 0));
      end else if (r < 70) begin
        m = make_cmd(OP_TRI, rand_vertex(), rand_vertex(), rand_vertex(), 0, 0, 0);
      end else if (r < 95) begin
        m = make_cmd(OP_READ, rand_vertex(), 0, 0, 0, 0, 0);
      end else begin
        m = make_cmd(OP_NOP, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), 0, 0, 0);
      end
      // Unused fields carry noise so that every bit is toggled.
      if (m.op != OP_WRITE && $urandom_range(0, 1)) begin
        m.px = POS_W'($urandom);
        m.py = POS_W'($urandom);
        m.pz = POS_W'($urandom);
      end
      if (m.op != OP_TRI && $urandom_range(0, 1)) begin
        m.ib = IDX_W'($urandom);
        m.ic = IDX_W'($urandom);
      end
      m.drain = (i == NUM_RANDOM / 2);
      queue_cmd(m);
    end
    planned_count = cmd_queue.size();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (cmd_queue.size() == 0 && !in_valid && expected_normals.size() == 0);
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_normals.size() == 0) begin
      $display("vertex_normal_accumulator_top_test: PASS");
    end else begin
      $display("vertex_normal_accumulator_top_test: FAIL");
    end
    $finish;
  end

endmodule
